@@ rtl/core/fmbq_pkg.sv @@
`timescale 1ns / 1ps

package fmbq_pkg;

    localparam int WORD_W           = 32;
    localparam int DEFAULT_CAPACITY = 64;

    localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [2:0] ACT_PUSH_MID   = 3'd1;
    localparam logic [2:0] ACT_PUSH_BACK  = 3'd2;
    localparam logic [2:0] ACT_POP_FRONT  = 3'd3;
    localparam logic [2:0] ACT_POP_MID    = 3'd4;
    localparam logic [2:0] ACT_POP_BACK   = 3'd5;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // broadcast to every cell in the chain
    typedef struct packed {
        logic ins;
        logic rem;
    } cell_ctl_t;

endpackage

@@ rtl/core/fmbq_cell.sv @@
`timescale 1ns / 1ps

module fmbq_cell
    import fmbq_pkg::*;
#(
    parameter int IDX = 0,
    parameter int IW  = 6,
    parameter int CW  = 7
)
(
    input  logic                     clk,
    input  cell_ctl_t                ctl,
    input  logic [IW-1:0]            pos,
    input  logic [CW-1:0]            count,
    input  logic signed [WORD_W-1:0] word,
    input  logic signed [WORD_W-1:0] left,
    input  logic signed [WORD_W-1:0] right,
    output logic signed [WORD_W-1:0] q,
    output logic signed [WORD_W-1:0] sel_word
);

    localparam logic [IW-1:0] IDX_P  = IW'(IDX);
    localparam logic [CW-1:0] IDX_C  = CW'(IDX);
    localparam logic [CW-1:0] IDX1_C = CW'(IDX + 1);

    logic signed [WORD_W-1:0] data_reg;
    logic signed [WORD_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.ins)
        begin
            if (IDX_P == pos)
                data_next = word;
            else if (IDX_P > pos && IDX_C <= count)
                data_next = left;
        end
        else if (ctl.rem)
        begin
            // close the gap: take the right neighbor's word
            if (IDX_P >= pos && IDX1_C < count)
                data_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q        = data_reg;
    assign sel_word = (IDX_P == pos) ? data_reg : '0;

endmodule

@@ rtl/core/fmbq_ctrl.sv @@
`timescale 1ns / 1ps

module fmbq_ctrl
    import fmbq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY,
    parameter int IW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     acc,
    input  logic [2:0]               action,
    input  logic signed [WORD_W-1:0] sel_word,
    output cell_ctl_t                ctl,
    output logic [IW-1:0]            pos,
    output logic [CW-1:0]            count,
    output logic                     done,
    output logic [1:0]               status,
    output logic signed [WORD_W-1:0] pop_value
);

    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [CW-1:0]            count_reg, count_next;
    logic                     done_reg;
    logic [1:0]               status_reg, status_next;
    logic signed [WORD_W-1:0] pop_value_reg, pop_value_next;
    logic                     is_push, is_pop, full, empty;
    logic [CW-1:0]            last;

    assign is_push = (action == ACT_PUSH_FRONT) || (action == ACT_PUSH_MID)
                  || (action == ACT_PUSH_BACK);
    assign is_pop  = (action == ACT_POP_FRONT) || (action == ACT_POP_MID)
                  || (action == ACT_POP_BACK);
    assign full    = (count_reg == CAP_C);
    assign empty   = (count_reg == '0);
    assign last    = count_reg - CW'(1);

    assign ctl.ins = acc && is_push && !full;
    assign ctl.rem = acc && is_pop && !empty;

    always_comb
    begin
        unique case (action)
            ACT_PUSH_FRONT: pos = '0;
            ACT_PUSH_MID:   pos = IW'(count_reg >> 1);
            ACT_PUSH_BACK:  pos = IW'(count_reg);
            ACT_POP_FRONT:  pos = '0;
            ACT_POP_MID:    pos = IW'(last >> 1);
            ACT_POP_BACK:   pos = IW'(last);
            default:        pos = '0;
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        status_next    = ST_DONE;
        pop_value_next = '0;
        if (ctl.ins)
            count_next = count_reg + CW'(1);
        else if (ctl.rem)
        begin
            count_next     = last;
            pop_value_next = sel_word;
        end
        if (is_push && full)
            status_next = ST_FULL;
        else if (is_pop && empty)
            status_next = ST_EMPTY;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            done_reg      <= 1'b0;
            status_reg    <= ST_DONE;
            pop_value_reg <= '0;
        end
        else
        begin
            done_reg <= acc;
            if (acc)
            begin
                count_reg     <= count_next;
                status_reg    <= status_next;
                pop_value_reg <= pop_value_next;
            end
        end
    end

    assign count     = count_reg;
    assign done      = done_reg;
    assign status    = status_reg;
    assign pop_value = pop_value_reg;

`ifndef NO_ASSERTIONS
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> done_reg)
        else $error("result strobe missing after request");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("entry count above capacity");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && is_push && !full) |=> (count_reg == $past(count_reg) + CW'(1)
                                       && status_reg == ST_DONE))
        else $error("push did not grow the queue");

    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && is_pop && empty) |=> (status_reg == ST_EMPTY
                                      && pop_value_reg == '0 && count_reg == '0))
        else $error("empty pop misreported");
`endif

endmodule

@@ rtl/core/front_middle_back_queue.sv @@
`timescale 1ns / 1ps

// Channel   Handshake           Ports
// request   start & !busy       action, push_value
// result    done (one cycle)    status, pop_value, entry_count
//
// One request per cycle; its result strobes on done in the next cycle.
// Every word sits in its own cell; the cells from pos on shift left or
// right together, so insert or remove at any position completes when taken.
// busy is never raised. rst_n (async) empties the queue; cell contents
// are left as they are. The receiver cannot stall the result.

module front_middle_back_queue
    import fmbq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [2:0]                           action,
    input  logic signed [WORD_W-1:0]             push_value,
    output logic                                 done,
    output logic [1:0]                           status,
    output logic signed [WORD_W-1:0]             pop_value,
    output logic [$clog2(CAPACITY + 1)-1:0]      entry_count
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    cell_ctl_t                ctl;
    logic [IW-1:0]            pos;
    logic [CW-1:0]            count;
    logic                     acc;
    logic signed [WORD_W-1:0] cell_q   [CAPACITY];
    logic signed [WORD_W-1:0] cell_sel [CAPACITY];
    logic signed [WORD_W-1:0] sel_word;

    assign busy = 1'b0;
    assign acc  = start && !busy;

    fmbq_ctrl #(
        .CAPACITY (CAPACITY),
        .IW       (IW),
        .CW       (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc       (acc),
        .action    (action),
        .sel_word  (sel_word),
        .ctl       (ctl),
        .pos       (pos),
        .count     (count),
        .done      (done),
        .status    (status),
        .pop_value (pop_value)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        fmbq_cell #(
            .IDX (i),
            .IW  (IW),
            .CW  (CW)
        ) u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .pos      (pos),
            .count    (count),
            .word     (push_value),
            .left     ((i == 0) ? push_value : cell_q[(i == 0) ? 0 : i - 1]),
            .right    ((i == CAPACITY - 1) ? cell_q[i]
                                           : cell_q[(i == CAPACITY - 1) ? i : i + 1]),
            .q        (cell_q[i]),
            .sel_word (cell_sel[i])
        );
    end

    // only the addressed cell drives a nonzero word
    always_comb
    begin
        sel_word = '0;
        for (int k = 0; k < CAPACITY; k++)
            sel_word = sel_word | cell_sel[k];
    end

    assign entry_count = count;

endmodule

@@ verif/front_middle_back_queue_test.sv @@
`timescale 1ns / 1ps

module front_middle_back_queue_test;

    import fmbq_pkg::*;

    localparam int DEPTH         = DEFAULT_CAPACITY;
    localparam int COUNT_W       = $clog2(DEPTH + 1);
    localparam int RANDOM_TOTAL  = 1650;
    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_REPORTED  = 10;
    localparam int TAIL_CYCLES   = 4;
    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    typedef struct {
        logic [2:0]               act;
        logic signed [WORD_W-1:0] word;
        int                       idle_pct;
        bit                       drain_first;
    } request_t;

    typedef struct {
        logic [1:0]               status;
        logic signed [WORD_W-1:0] pop_value;
        logic [COUNT_W-1:0]       entry_count;
    } queue_result_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic [2:0]                   action = ACT_PUSH_FRONT;
    logic signed [WORD_W-1:0]     push_value = '0;
    logic                         done;
    logic [1:0]                   status;
    logic signed [WORD_W-1:0]     pop_value;
    logic [COUNT_W-1:0]           entry_count;

    request_t                     pending_requests[$];
    queue_result_t                awaited_results[$];
    logic signed [WORD_W-1:0]     queue_image[$];
    request_t                     next_req;
    queue_result_t                head_result;
    logic                         drained = 1'b1;
    int                           mismatch_count = 0;
    int                           quiet_cycles = 0;

    front_middle_back_queue #(.CAPACITY(DEPTH)) dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .push_value  (push_value),
        .done        (done),
        .status      (status),
        .pop_value   (pop_value),
        .entry_count (entry_count)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Applies one request to the mirror of the queue and returns its result.
    function automatic queue_result_t queue_step(logic [2:0] act, logic signed [WORD_W-1:0] word);
        queue_result_t r;
        int n;
        r.status    = ST_DONE;
        r.pop_value = '0;
        n = queue_image.size();
        case (act)
            ACT_PUSH_FRONT, ACT_PUSH_MID, ACT_PUSH_BACK:
            begin
                if (n >= DEPTH)
                    r.status = ST_FULL;
                else if (act == ACT_PUSH_FRONT)
                    queue_image.insert(0, word);
                else if (act == ACT_PUSH_MID)
                    queue_image.insert(n / 2, word);
                else
                    queue_image.insert(n, word);
            end
            ACT_POP_FRONT, ACT_POP_MID, ACT_POP_BACK:
            begin
                if (n == 0)
                    r.status = ST_EMPTY;
                else if (act == ACT_POP_FRONT)
                begin
                    r.pop_value = queue_image[0];
                    queue_image.delete(0);
                end
                else if (act == ACT_POP_MID)
                begin
                    // front-most of the two middle cells
                    r.pop_value = queue_image[(n - 1) / 2];
                    queue_image.delete((n - 1) / 2);
                end
                else
                begin
                    r.pop_value = queue_image[n - 1];
                    queue_image.delete(n - 1);
                end
            end
            default:
            begin
            end
        endcase
        r.entry_count = COUNT_W'(queue_image.size());
        return r;
    endfunction

    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(15))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_request(logic [2:0] act, logic signed [WORD_W-1:0] word,
                               int idle_pct, bit drain_first);
        request_t r;
        r.act         = act;
        r.word        = word;
        r.idle_pct    = idle_pct;
        r.drain_first = drain_first;
        pending_requests.insert(pending_requests.size(), r);
    endtask

    // Random phase built from fill- and drain-biased runs so the queue
    // swings between empty and full.
    task automatic add_phase(int count, int idle_pct);
        int bias[5];
        int run_len;
        int push_pct;
        int k;
        logic [2:0] act;
        bias = '{92, 75, 50, 25, 8};
        k = 0;
        while (k < count)
        begin
            run_len  = $urandom_range(20, 120);
            if (run_len > count - k)
                run_len = count - k;
            push_pct = bias[$urandom_range(4)];
            repeat (run_len)
            begin
                if ($urandom_range(99) < 2)
                    act = $urandom_range(1) ? ACT_SPARE_HI : ACT_SPARE_LO;
                else if ($urandom_range(99) < push_pct)
                begin
                    act = 3'($urandom_range(ACT_PUSH_BACK, ACT_PUSH_FRONT));
                    k++;
                end
                else
                begin
                    act = 3'($urandom_range(ACT_POP_BACK, ACT_POP_FRONT));
                    k++;
                end
                add_request(act, pick_word(), idle_pct, k == 1);
            end
        end
    endtask

    task automatic flag_mismatch(string what);
        if (mismatch_count < MAX_REPORTED)
            $display("[%0t] %s", $realtime, what);
        mismatch_count++;
    endtask

    // Driver: a new request goes out once the current one is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            action     <= ACT_PUSH_FRONT;
            push_value <= '0;
        end
        else if (!start || !busy)
        begin
            if (pending_requests.size() != 0
                && (!pending_requests[0].drain_first || (!start && drained))
                && $urandom_range(99) >= pending_requests[0].idle_pct)
            begin
                next_req    = pending_requests[0];
                pending_requests.delete(0);
                start      <= 1'b1;
                action     <= next_req.act;
                push_value <= next_req.word;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: check the result strobe, then record what was just accepted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (awaited_results.size() == 0)
                    flag_mismatch($sformatf(
                        "result with nothing pending: status %0d pop %0d count %0d",
                        status, pop_value, entry_count));
                else
                begin
                    head_result = awaited_results[0];
                    awaited_results.delete(0);
                    if (status !== head_result.status)
                        flag_mismatch($sformatf("status: expected %0d, got %0d",
                                                head_result.status, status));
                    if (pop_value !== head_result.pop_value)
                        flag_mismatch($sformatf("pop_value: expected %0d, got %0d",
                                                head_result.pop_value, pop_value));
                    if (entry_count !== head_result.entry_count)
                        flag_mismatch($sformatf("entry_count: expected %0d, got %0d",
                                                head_result.entry_count, entry_count));
                end
            end
            if (start && !busy)
                awaited_results.insert(awaited_results.size(),
                                       queue_step(action, push_value));
            drained <= (awaited_results.size() == 0);

            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        // empty pops, pushes of extreme words, pops at odd and even counts,
        // spare action codes
        add_request(ACT_POP_FRONT,  32'sd5,           0, 1'b0);
        add_request(ACT_POP_MID,    32'sd6,           0, 1'b0);
        add_request(ACT_POP_BACK,   32'sd7,           0, 1'b0);
        add_request(ACT_PUSH_BACK,  32'sh7fff_ffff,   0, 1'b0);
        add_request(ACT_PUSH_FRONT, 32'sh8000_0000,   0, 1'b0);
        add_request(ACT_PUSH_MID,   '0,               0, 1'b0);
        add_request(ACT_PUSH_MID,   -32'sd1,          0, 1'b0);
        add_request(ACT_PUSH_BACK,  32'sd1,           0, 1'b0);
        add_request(ACT_PUSH_FRONT, 32'sh1234_5678,   0, 1'b0);
        add_request(ACT_PUSH_MID,   32'sh5555_aaaa,   0, 1'b0);
        add_request(ACT_POP_MID,    '0,               0, 1'b0);
        add_request(ACT_POP_FRONT,  -32'sd1,          0, 1'b0);
        add_request(ACT_POP_BACK,   '0,               0, 1'b0);
        add_request(ACT_POP_MID,    '0,               0, 1'b0);
        add_request(ACT_SPARE_LO,   32'sh0f0f_0f0f,   0, 1'b0);
        add_request(ACT_PUSH_MID,   32'sh2468_ace0,   0, 1'b0);
        add_request(ACT_SPARE_HI,   -32'sd1,          0, 1'b0);
        add_request(ACT_POP_MID,    '0,               0, 1'b0);
        add_request(ACT_POP_BACK,   '0,               0, 1'b0);
        add_request(ACT_POP_FRONT,  '0,               0, 1'b0);
        add_request(ACT_POP_FRONT,  '0,               0, 1'b0);
        add_request(ACT_PUSH_BACK,  32'sh4000_0001,   0, 1'b0);
        add_request(ACT_POP_MID,    '0,               0, 1'b0);
        add_request(ACT_POP_MID,    '0,               0, 1'b0);

        add_phase(RANDOM_TOTAL / 4, 0);
        add_phase(RANDOM_TOTAL / 4, 88);
        add_phase(RANDOM_TOTAL / 4, 0);
        add_phase(RANDOM_TOTAL / 4, 33);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (pending_requests.size() != 0 || start || !drained || done);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
